// ===== rtl/cwma_pkg.sv =====
// Package for the checked word memory allocator.
// Holds request and status codes, the controller state type and the row search helper.
// No dependencies.
`default_nettype none

package cwma_pkg;

  // request operation codes
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FREE  = 2'd2,
    OP_ALLOC = 2'd3
  } op_t;

  // response status codes
  localparam logic [2:0] STATUS_OK     = 3'd0;
  localparam logic [2:0] STATUS_RANGE  = 3'd1;
  localparam logic [2:0] STATUS_ALIGN  = 3'd2;
  localparam logic [2:0] STATUS_UNUSED = 3'd3;
  localparam logic [2:0] STATUS_FULL   = 3'd4;

  // in-use bits are kept in rows of this many words
  localparam int ROW_BITS  = 32;
  localparam int ROW_SEL_W = 5;

  // controller states
  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_ACCESS = 4'b0100,
    S_HOLD   = 4'b1000
  } state_t;

  // position of the lowest clear bit of a row (row must not be all ones)
  function automatic logic [ROW_SEL_W-1:0] lowest_zero(input logic [ROW_BITS-1:0] row);
    logic [ROW_SEL_W-1:0] pos;
    pos = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (!row[i]) begin
        pos = ROW_SEL_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cwma_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// Standalone; used for the word store and the in-use row map.
`default_nettype none

module cwma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/checked_word_memory_allocator_unit.sv =====
// Checked word memory allocator: controller, word store and in-use row map.
// Depends on cwma_pkg and cwma_ram.
//
// A store of NUM_WORDS 32-bit words addressed by byte address, each word with an in-use
// bit. After reset the block runs a clearing pass (req_stall held high) that zeroes the
// word store and the in-use map, padding bits apart. After that a read, write or free is
// accepted, which starts the memory reads, and is then checked, modified and written back
// in the access state. An allocate scans from row to row, past each fully used row of 32
// words, until it finds a free word or runs out: a pointer to the lowest row that may hold
// a free word is kept, so a scan starts there and usually ends in its first row. The
// response sits in an output register, so the next request is accepted while a response
// still waits to be taken.
`default_nettype none

module checked_word_memory_allocator_unit #(
  parameter int NUM_WORDS = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire logic [1:0]         operation,
  input  wire logic [11:0]        address,
  input  wire logic signed [31:0] write_value,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output logic [2:0]              status,
  output logic signed [31:0]      result_data
);

  import cwma_pkg::*;

  localparam int ROWS  = (NUM_WORDS + ROW_BITS - 1) / ROW_BITS;
  localparam int ROWW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDXW  = $clog2(NUM_WORDS);
  localparam int PIDXW = ROWW + ROW_SEL_W;
  localparam int HINTW = $clog2(ROWS + 1);
  localparam int PAD   = ROWS * ROW_BITS - NUM_WORDS;
  localparam int unsigned LIMIT = NUM_WORDS * 4;
  // padding bits past the last word read as in use
  localparam logic [ROW_BITS-1:0] LAST_ROW_INIT = {ROW_BITS{1'b1}} << (ROW_BITS - PAD);

  // controller state
  state_t            state, state_next;
  logic [IDXW-1:0]   clr_cnt;
  logic [HINTW-1:0]  hint, hint_next;

  // latched request
  op_t                  cur_op;
  logic [IDXW-1:0]      cur_widx;
  logic [ROWW-1:0]      cur_row;
  logic [ROW_SEL_W-1:0] cur_bit;
  logic                 cur_in_range;
  logic                 cur_aligned;
  logic [31:0]          cur_wval;

  // held response when the output register is busy
  logic [2:0]  held_status;
  logic [31:0] held_data;

  // memory ports
  logic                word_we;
  logic [IDXW-1:0]     word_waddr, word_raddr;
  logic [31:0]         word_wdata, word_rdata;
  logic                map_we;
  logic [ROWW-1:0]     map_waddr, map_raddr;
  logic [ROW_BITS-1:0] map_wdata, map_rdata;

  // request decode
  logic [PIDXW-1:0]     req_pidx;
  logic [ROWW-1:0]      req_row;
  logic [ROW_SEL_W-1:0] req_bit;
  logic                 req_in_range;
  logic                 accept;

  // access-cycle results
  logic                 done;
  logic [2:0]           res_status;
  logic [31:0]          res_data;
  logic                 hint_full;
  logic [HINTW-1:0]     hint_inc;
  logic                 hint_inc_full;
  logic [ROWW-1:0]      hint_row;
  logic [ROW_SEL_W-1:0] zero_pos;
  logic                 row_has_free;
  logic                 out_free;
  logic                 load_now, load_held;

  assign req_stall    = (state != S_IDLE);
  assign accept       = req_valid && !req_stall;
  assign req_pidx     = PIDXW'(address[11:2]);
  assign req_row      = req_pidx[PIDXW-1:ROW_SEL_W];
  assign req_bit      = req_pidx[ROW_SEL_W-1:0];
  assign req_in_range = (32'(address) < LIMIT);

  assign hint_full     = (32'(hint) == ROWS);
  assign hint_inc      = hint + 1'b1;
  assign hint_inc_full = (32'(hint_inc) == ROWS);
  assign hint_row      = hint_full ? '0 : hint[ROWW-1:0];
  assign zero_pos      = lowest_zero(map_rdata);
  assign row_has_free  = !(&map_rdata);
  assign out_free      = !rsp_valid || !rsp_stall;

  cwma_ram #(.WIDTH(32), .DEPTH(NUM_WORDS)) u_word_ram (
    .clk   (clk),
    .we    (word_we),
    .waddr (word_waddr),
    .wdata (word_wdata),
    .raddr (word_raddr),
    .rdata (word_rdata)
  );

  cwma_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // read addresses: request word and row (pointer row for an allocate) on accept, next row while scanning
  always_comb begin
    word_raddr = IDXW'(address[11:2]);
    map_raddr  = '0;
    if (state == S_IDLE) begin
      map_raddr = (op_t'(operation) == OP_ALLOC) ? hint_row : req_row;
    end else if (state == S_ACCESS && !hint_inc_full) begin
      map_raddr = hint_inc[ROWW-1:0];
    end
  end

  // clearing writes; check, modify and write back
  always_comb begin
    word_we    = 1'b0;
    word_waddr = cur_widx;
    word_wdata = cur_wval;
    map_we     = 1'b0;
    map_waddr  = cur_row;
    map_wdata  = map_rdata;
    done       = 1'b0;
    res_status = STATUS_OK;
    res_data   = '0;
    hint_next  = hint;
    unique case (state)
      S_CLEAR: begin
        word_we    = 1'b1;
        word_waddr = clr_cnt;
        word_wdata = '0;
        map_we     = (32'(clr_cnt) < ROWS);
        map_waddr  = clr_cnt[ROWW-1:0];
        map_wdata  = (clr_cnt[ROWW-1:0] == ROWW'(ROWS - 1)) ? LAST_ROW_INIT : '0;
      end
      S_ACCESS: begin
        unique case (cur_op)
          OP_READ: begin
            done = 1'b1;
            if (!cur_in_range) begin
              res_status = STATUS_RANGE;
            end else if (!cur_aligned) begin
              res_status = STATUS_ALIGN;
            end else if (!map_rdata[cur_bit]) begin
              res_status = STATUS_UNUSED;
            end else begin
              res_data = word_rdata;
            end
          end
          OP_WRITE: begin
            done = 1'b1;
            if (!cur_in_range) begin
              res_status = STATUS_RANGE;
            end else if (!cur_aligned) begin
              res_status = STATUS_ALIGN;
            end else begin
              word_we            = 1'b1;
              map_we             = 1'b1;
              map_wdata[cur_bit] = 1'b1;
            end
          end
          OP_FREE: begin
            done = 1'b1;
            if (cur_in_range) begin
              map_we             = 1'b1;
              map_wdata[cur_bit] = 1'b0;
              if (HINTW'(cur_row) < hint) begin
                hint_next = HINTW'(cur_row);
              end
            end
          end
          OP_ALLOC: begin
            map_waddr = hint_row;
            if (hint_full) begin
              done       = 1'b1;
              res_status = STATUS_FULL;
            end else if (row_has_free) begin
              done                = 1'b1;
              map_we              = 1'b1;
              map_wdata[zero_pos] = 1'b1;
              res_data            = 32'({hint_row, zero_pos, 2'b00});
            end else begin
              // row fully used: move the pointer and look at the next row
              hint_next = hint_inc;
              if (hint_inc_full) begin
                done       = 1'b1;
                res_status = STATUS_FULL;
              end
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  assign load_now  = (state == S_ACCESS) && done && out_free;
  assign load_held = (state == S_HOLD) && out_free;

  // state sequencing
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_cnt == IDXW'(NUM_WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_ACCESS;
        end
      end
      S_ACCESS: begin
        if (done) begin
          state_next = out_free ? S_IDLE : S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      hint      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      hint  <= hint_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (load_now || load_held) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_op       <= op_t'(operation);
      cur_widx     <= IDXW'(address[11:2]);
      cur_row      <= req_row;
      cur_bit      <= req_bit;
      cur_in_range <= req_in_range;
      cur_aligned  <= (address[1:0] == 2'b00);
      cur_wval     <= write_value;
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if (state == S_ACCESS && done && !out_free) begin
      held_status <= res_status;
      held_data   <= res_data;
    end
    if (load_now) begin
      status      <= res_status;
      result_data <= res_data;
    end else if (load_held) begin
      status      <= held_status;
      result_data <= held_data;
    end
  end

`ifndef SYNTH
  // the free-row pointer never passes the row count
  a_hint_bound: assert property (@(posedge clk) disable iff (rst)
    32'(hint) <= ROWS)
    else $error("free-row pointer beyond row count");

  // an accepted request goes straight to the memory access cycle
  a_accept_access: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_ACCESS)
    else $error("accepted request did not reach access cycle");

  // no response leaves during the clearing pass
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !rsp_valid)
    else $error("response during clearing pass");

  // a held result only exists while the output register is occupied
  a_hold_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_HOLD |-> rsp_valid)
    else $error("holding a result with an empty output register");
`endif

endmodule

`default_nettype wire

// ===== test/checked_word_memory_allocator_unit_tb.sv =====
// Self-checking testbench for checked_word_memory_allocator_unit.
// Runs directed and random read/write/free/allocate traffic and checks every response.
// Depends on cwma_pkg and the block's RTL.
`default_nettype none

module checked_word_memory_allocator_unit_tb;
  import cwma_pkg::*;

  localparam int NUM_WORDS   = 256;
  localparam int CYCLE_LIMIT = 300000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] data;
  } mem_rsp_t;

  // Predicts the response of each accepted request and checks the block's output
  class alloc_scoreboard;
    logic [31:0] word_store [NUM_WORDS];
    bit          in_use [NUM_WORDS];
    mem_rsp_t    rsp_q [$];
    int          mismatches;
    int          op_count [4];
    int          status_count [5];

    function new();
      foreach (word_store[i]) begin
        word_store[i] = '0;
        in_use[i]     = 1'b0;
      end
      mismatches = 0;
      foreach (op_count[i]) op_count[i] = 0;
      foreach (status_count[i]) status_count[i] = 0;
    endfunction

    function int pending();
      return rsp_q.size();
    endfunction

    function bit map_full();
      foreach (in_use[i]) begin
        if (!in_use[i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    // aligned byte address, biased toward words in use
    function logic [11:0] pick_used_addr();
      int idx;
      idx = $urandom_range(0, NUM_WORDS - 1);
      for (int tries = 0; tries < 16 && !in_use[idx]; tries++) begin
        idx = $urandom_range(0, NUM_WORDS - 1);
      end
      return 12'(idx * 4);
    endfunction

    // update the word store and in-use map, queue the response
    function void note_request(op_t op, logic [11:0] addr, logic [31:0] wval);
      mem_rsp_t   rsp;
      logic [2:0] addr_check;
      int         idx;
      bit         found;
      rsp.status = STATUS_OK;
      rsp.data   = '0;
      idx        = int'(addr >> 2);
      found      = 1'b0;
      // range first, then alignment
      if (int'(addr) >= NUM_WORDS * 4) addr_check = STATUS_RANGE;
      else if (addr[1:0] != 2'b00) addr_check = STATUS_ALIGN;
      else addr_check = STATUS_OK;
      case (op)
        OP_READ: begin
          rsp.status = addr_check;
          if (addr_check == STATUS_OK) begin
            if (in_use[idx]) rsp.data = word_store[idx];
            else rsp.status = STATUS_UNUSED;
          end
        end
        OP_WRITE: begin
          rsp.status = addr_check;
          if (addr_check == STATUS_OK) begin
            word_store[idx] = wval;
            in_use[idx]     = 1'b1;
          end
        end
        OP_FREE: begin
          // misaligned frees still clear word addr/4; out of range is ignored
          if (idx < NUM_WORDS) in_use[idx] = 1'b0;
        end
        default: begin
          for (int i = 0; i < NUM_WORDS && !found; i++) begin
            if (!in_use[i]) begin
              found     = 1'b1;
              in_use[i] = 1'b1;
              rsp.data  = 32'(i * 4);
            end
          end
          if (!found) rsp.status = STATUS_FULL;
        end
      endcase
      op_count[op]++;
      status_count[rsp.status]++;
      rsp_q.push_back(rsp);
    endfunction

    function void report(string what, mem_rsp_t exp_rsp, logic [2:0] st, logic [31:0] data);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%s: expected status %0d data %h, got status %0d data %h",
                 what, exp_rsp.status, exp_rsp.data, st, data);
      end
    endfunction

    function void check_response(logic [2:0] st, logic [31:0] data);
      mem_rsp_t exp_rsp;
      if (rsp_q.size() == 0) begin
        exp_rsp = '0;
        report("response with none outstanding", exp_rsp, st, data);
      end else begin
        exp_rsp = rsp_q.pop_front();
        if (st !== exp_rsp.status || data !== exp_rsp.data) begin
          report("response mismatch", exp_rsp, st, data);
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst         = 1'b1;
  logic               req_valid   = 1'b0;
  logic               req_stall;
  logic [1:0]         operation   = '0;
  logic [11:0]        address     = '0;
  logic signed [31:0] write_value = '0;
  logic               rsp_valid;
  logic               rsp_stall   = 1'b0;
  logic [2:0]         status;
  logic signed [31:0] result_data;

  alloc_scoreboard sb = new();
  int req_idle_pct  = 0;
  int rsp_stall_pct = 0;
  int cycle_count   = 0;

  checked_word_memory_allocator_unit #(
    .NUM_WORDS(NUM_WORDS)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .operation  (operation),
    .address    (address),
    .write_value(write_value),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .status     (status),
    .result_data(result_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // response side: check accepted responses, stall at random
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) sb.check_response(status, result_data);
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("checked_word_memory_allocator_unit verification failed");
      $finish;
    end
  end

  // drive one request, with random idle cycles ahead of it; returns at its acceptance edge
  task automatic send_request(input op_t op, input logic [11:0] addr, input logic [31:0] wval);
    while ($urandom_range(0, 99) < req_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid   <= 1'b1;
    operation   <= op;
    address     <= addr;
    write_value <= wval;
    do @(posedge clk); while (req_stall);
    sb.note_request(op, addr, wval);
  endtask

  // hold off until every outstanding response has come back
  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // mostly well-formed traffic, some noise
  task automatic random_request();
    int          pick;
    logic [31:0] wval;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 7))
      0: wval = 32'h7fff_ffff;
      1: wval = 32'h8000_0000;
      2: wval = 32'hffff_ffff;
      default: wval = $urandom();
    endcase
    if (pick < 28) begin
      send_request(OP_READ, ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 255) * 4)
                                                        : sb.pick_used_addr(), wval);
    end else if (pick < 50) begin
      send_request(OP_WRITE, ($urandom_range(0, 2) == 0) ? 12'($urandom_range(0, 255) * 4)
                                                         : sb.pick_used_addr(), wval);
    end else if (pick < 72) begin
      send_request(OP_FREE, sb.pick_used_addr(), wval);
    end else if (pick < 88) begin
      send_request(OP_ALLOC, 12'($urandom_range(0, 4095)), wval);
    end else begin
      send_request(op_t'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)), $urandom());
    end
  endtask

  // allocate until the map is full, then twice more
  task automatic fill_map();
    while (!sb.map_full()) send_request(OP_ALLOC, 12'($urandom_range(0, 4095)), $urandom());
    repeat (2) send_request(OP_ALLOC, 12'($urandom_range(0, 4095)), $urandom());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes and each corner of the access checks
    send_request(OP_READ,  12'd0,    32'h0);          // read of a word not in use
    send_request(OP_WRITE, 12'd0,    32'h7fff_ffff);  // write without allocate
    send_request(OP_READ,  12'd0,    32'h0);
    send_request(OP_WRITE, 12'd1020, 32'h8000_0000);  // last word
    send_request(OP_READ,  12'd1020, 32'hffff_ffff);
    send_request(OP_WRITE, 12'd1024, 32'hffff_ffff);  // first address out of range
    send_request(OP_READ,  12'd4095, 32'h0);          // out of range and misaligned
    send_request(OP_WRITE, 12'd2,    32'h1234_5678);  // misaligned
    send_request(OP_READ,  12'd1023, 32'h0);
    send_request(OP_ALLOC, 12'd4095, 32'hffff_ffff);  // lowest free word, address ignored
    send_request(OP_WRITE, 12'd4,    32'hffff_ffff);
    send_request(OP_FREE,  12'd4,    32'h0);
    send_request(OP_FREE,  12'd4,    32'h0);          // free of a word not in use
    send_request(OP_READ,  12'd4,    32'h0);
    send_request(OP_ALLOC, 12'd0,    32'h0);          // reclaims word 1, data kept
    send_request(OP_READ,  12'd4,    32'h0);
    send_request(OP_FREE,  12'd3,    32'h0);          // misaligned free clears word 0
    send_request(OP_READ,  12'd0,    32'h0);
    send_request(OP_FREE,  12'd2000, 32'h0);          // out of range free is ignored
    send_request(OP_FREE,  12'd4095, 32'h0);
    send_request(OP_WRITE, 12'd8,    32'h0);
    send_request(OP_READ,  12'd8,    32'h0);
    send_request(OP_READ,  12'd1021, 32'h0);

    // random traffic over the idle and stall mixes
    for (int phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
        1: begin req_idle_pct = 51; rsp_stall_pct = 0;  end
        2: begin req_idle_pct = 0;  rsp_stall_pct = 51; end
        default: begin req_idle_pct = 20; rsp_stall_pct = 20; end
      endcase
      for (int n = 0; n < 370; n++) begin
        if (n == 150 && (phase == 0 || phase == 3)) fill_map();
        random_request();
      end
    end

    drain();
    repeat (16) @(posedge clk);
    $display("requests: read %0d, write %0d, free %0d, allocate %0d",
             sb.op_count[OP_READ], sb.op_count[OP_WRITE], sb.op_count[OP_FREE],
             sb.op_count[OP_ALLOC]);
    $display("responses by status: ok %0d, range %0d, align %0d, unused %0d, full %0d",
             sb.status_count[STATUS_OK], sb.status_count[STATUS_RANGE],
             sb.status_count[STATUS_ALIGN], sb.status_count[STATUS_UNUSED],
             sb.status_count[STATUS_FULL]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("checked_word_memory_allocator_unit verification clean");
    end else begin
      $display("%0d mismatches, %0d responses missing", sb.mismatches, sb.pending());
      $display("checked_word_memory_allocator_unit verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/cwma_pkg.sv
rtl/cwma_ram.sv
rtl/checked_word_memory_allocator_unit.sv
test/checked_word_memory_allocator_unit_tb.sv
